[src/servo_pulse_train_sequencer_macros.svh]
// assertion helpers shared by the sequencer rtl
`ifndef SERVO_PULSE_TRAIN_SEQUENCER_MACROS_SVH
`define SERVO_PULSE_TRAIN_SEQUENCER_MACROS_SVH

// condition must hold at every edge out of reset
`define SPTS_CHECK(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define SPTS_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/spts_pkg.sv]
package spts_pkg;

   localparam int ACTION_BITS    = 2;
   localparam int CHANNEL_BITS   = 3;
   localparam int REQ_WIDTH_BITS = 16;
   localparam int CUR_BITS       = 4;
   localparam int TOTAL_BITS     = 19;
   localparam int ELAPSED_BITS   = 21;
   localparam int EXTRA_BITS     = 3;
   localparam int HMS_BITS       = 14;
   localparam int FRAME_BITS     = 20;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 20;
   localparam int BASE_CHANNELS  = 4;

   localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;
   localparam logic [HMS_BITS-1:0]     HMS_RESET   = 14'd1000;
   localparam logic [FRAME_BITS-1:0]   FRAME_RESET = 20'd20000;

   // request actions
   localparam logic [ACTION_BITS-1:0] ACT_TICK  = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_SET   = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_START = 2'd2;
   localparam logic [ACTION_BITS-1:0] ACT_CLEAR = 2'd3;

   // register map
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXTRA = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ARMED = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HMS   = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME = 2'd3;

   typedef struct packed {
      logic [EXTRA_BITS-1:0] extra_channels;
      logic                  armed;
      logic [HMS_BITS-1:0]   half_ms_ticks;
      logic [FRAME_BITS-1:0] frame_ticks;
   } cfg_type;

   typedef struct packed {
      logic [ACTION_BITS-1:0]    action;
      logic [CHANNEL_BITS-1:0]   channel;
      logic [REQ_WIDTH_BITS-1:0] width;
   } item_type;

   typedef struct packed {
      logic                  clock_pulse;
      logic                  shift_data;
      logic                  shift_reset;
      logic                  frame_done;
      logic [CUR_BITS-1:0]   channel_now;
      logic [TOTAL_BITS-1:0] total_width;
   } result_type;

endpackage

[src/spts_if.sv]
interface spts_req_if import spts_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [ACTION_BITS-1:0]    action;
   logic [CHANNEL_BITS-1:0]   channel;
   logic [REQ_WIDTH_BITS-1:0] width;

   modport source (output valid, action, channel, width, input ready);
   modport sink (input valid, action, channel, width, output ready);
endinterface

interface spts_rsp_if import spts_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic                  clock_pulse;
   logic                  shift_data;
   logic                  shift_reset;
   logic                  frame_done;
   logic [CUR_BITS-1:0]   channel_now;
   logic [TOTAL_BITS-1:0] total_width;

   modport source (output valid, clock_pulse, shift_data, shift_reset, frame_done,
                   channel_now, total_width, input ready);
   modport sink (input valid, clock_pulse, shift_data, shift_reset, frame_done,
                 channel_now, total_width, output ready);
endinterface

[src/servo_pulse_train_sequencer.sv]
// Servo / ESC pulse-train sequencer for a shift-register fan-out chain.
// req_if carries one request per item: tick, width write, frame start or
// done clear. rsp_if returns exactly one response per request, in order,
// with the clock pulse, data and reset line levels, done flag, current
// channel and the total of the active channel widths after the update.
// csr_* writes extra_channels, armed, half_ms_ticks and frame_ticks; write
// only while no request is in flight.
// Timing: an accepted request waits in the read stage (s1) and commits
// into the response register once that is free or draining. Throughput:
// one request per cycle while rsp_if.ready stays high; the width memory
// read issued on acceptance is registered and consumed on commit, and a
// width write is forwarded to a read of the same entry in that cycle.
// Reset: registers return to their reset values, countdown to START_DELAY,
// and every width reads 1000 ticks (truncated to WIDTH_BITS) until written;
// no memory sweep is needed, the block is ready in the first cycle.
// Stall: while rsp_if.ready is low a valid response register holds; one more
// request may enter the read stage, after which req_if.ready drops.
module servo_pulse_train_sequencer import spts_pkg::*; #(
   parameter int MAX_CHANNELS = 8,
   parameter int START_DELAY  = 128,
   parameter int WIDTH_BITS   = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   spts_req_if.sink                  req_if,
   spts_rsp_if.source                rsp_if,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   logic       s1_valid_ff, s1_valid_in;
   item_type   s1_item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type result;
   logic       commit, load, accept;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_EXTRA: cfg_in.extra_channels = csr_wdata[EXTRA_BITS-1:0];
            CSR_ARMED: cfg_in.armed          = csr_wdata[0];
            CSR_HMS:   cfg_in.half_ms_ticks  = csr_wdata[HMS_BITS-1:0];
            CSR_FRAME: cfg_in.frame_ticks    = csr_wdata[FRAME_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.extra_channels <= '0;
         cfg_ff.armed          <= 1'b0;
         cfg_ff.half_ms_ticks  <= HMS_RESET;
         cfg_ff.frame_ticks    <= FRAME_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read stage commits when the response register is free or draining
   assign commit       = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign load         = !s1_valid_ff || commit;
   assign accept       = req_if.valid && load;
   assign req_if.ready = load;
   assign s1_valid_in  = load ? accept : s1_valid_ff;
   assign rsp_valid_in = commit ? 1'b1 : (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff.action  <= req_if.action;
         s1_item_ff.channel <= req_if.channel;
         s1_item_ff.width   <= req_if.width;
      end
      if (commit) begin
         rsp_ff <= result;
      end
   end

   spts_core #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .START_DELAY  (START_DELAY),
      .WIDTH_BITS   (WIDTH_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .load        (load),
      .req_channel (req_if.channel),
      .commit      (commit),
      .item        (s1_item_ff),
      .result      (result)
   );

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.clock_pulse = rsp_ff.clock_pulse;
   assign rsp_if.shift_data  = rsp_ff.shift_data;
   assign rsp_if.shift_reset = rsp_ff.shift_reset;
   assign rsp_if.frame_done  = rsp_ff.frame_done;
   assign rsp_if.channel_now = rsp_ff.channel_now;
   assign rsp_if.total_width = rsp_ff.total_width;

endmodule

[src/spts_width_mem.sv]
module spts_width_mem import spts_pkg::*; #(
   parameter int DEPTH     = 8,
   parameter int DATA_BITS = 16,
   parameter logic [DATA_BITS-1:0] RESET_VALUE = '0,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        ra_addr,
   input  logic [AW-1:0]        rb_addr,
   output logic [DATA_BITS-1:0] ra_data,
   output logic [DATA_BITS-1:0] rb_data
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]     valid_ff;
   logic [DATA_BITS-1:0] ra_data_ff;
   logic [DATA_BITS-1:0] rb_data_ff;
   logic                 ra_vld_ff;
   logic                 rb_vld_ff;

   // entries never written read as the reset width
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // write-first: a read of the entry being written returns the new value
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         if (wr_en && wr_addr == ra_addr) begin
            ra_data_ff <= wr_data;
            ra_vld_ff  <= 1'b1;
         end else begin
            ra_data_ff <= mem_ff[ra_addr];
            ra_vld_ff  <= valid_ff[ra_addr];
         end
         if (wr_en && wr_addr == rb_addr) begin
            rb_data_ff <= wr_data;
            rb_vld_ff  <= 1'b1;
         end else begin
            rb_data_ff <= mem_ff[rb_addr];
            rb_vld_ff  <= valid_ff[rb_addr];
         end
      end
   end

   assign ra_data = ra_vld_ff ? ra_data_ff : RESET_VALUE;
   assign rb_data = rb_vld_ff ? rb_data_ff : RESET_VALUE;

endmodule

[src/spts_core.sv]
`include "servo_pulse_train_sequencer_macros.svh"

module spts_core import spts_pkg::*; #(
   parameter int MAX_CHANNELS = 8,
   parameter int START_DELAY  = 128,
   parameter int WIDTH_BITS   = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    load,
   input  logic [CHANNEL_BITS-1:0] req_channel,
   input  logic                    commit,
   input  item_type                item,
   output result_type              result
);

   localparam int AW       = $clog2(MAX_CHANNELS);
   localparam int CD_BITS  = (WIDTH_BITS > $clog2(START_DELAY + 1)) ?
                             WIDTH_BITS : $clog2(START_DELAY + 1);
   localparam int NSUM     = MAX_CHANNELS - BASE_CHANNELS + 1;
   localparam int TOT_BITS = WIDTH_BITS + 3;
   localparam int CB       = ((WIDTH_BITS > REQ_WIDTH_BITS) ? WIDTH_BITS : REQ_WIDTH_BITS) + 1;
   localparam int ES_BITS  = ((WIDTH_BITS > ELAPSED_BITS) ? WIDTH_BITS : ELAPSED_BITS) + 1;
   localparam logic [WIDTH_BITS-1:0] RESET_WIDTH = WIDTH_BITS'(HMS_RESET);
   localparam logic [CB-1:0]         WMASK_EXT   = CB'((1 << WIDTH_BITS) - 1);
   localparam logic [CUR_BITS-1:0]   MAX_CUR     = CUR_BITS'(MAX_CHANNELS);

   logic [CUR_BITS-1:0]     cur_ff, cur_in;
   logic [ELAPSED_BITS-1:0] elapsed_ff, elapsed_in;
   logic [CD_BITS-1:0]      countdown_ff, countdown_in;
   logic                    done_ff, done_in;
   logic                    rst_line_ff, rst_line_in;
   logic [TOT_BITS-1:0]     sum_ff [NSUM];
   logic [TOT_BITS-1:0]     sum_in [NSUM];

   logic [WIDTH_BITS-1:0]   wa, wb;
   logic                    wr_en;
   logic [WIDTH_BITS-1:0]   wr_data;
   logic [AW-1:0]           ra_addr, rb_addr;
   logic [CUR_BITS-1:0]     n_full, n_act;
   logic [CB-1:0]           lo, hi, wreq, clamped;
   logic                    pulse, data;
   logic [TOT_BITS-1:0]     tot_sel;

   // active output count, saturated at the table size
   assign n_full = CUR_BITS'(BASE_CHANNELS) + CUR_BITS'(cfg.extra_channels);
   assign n_act  = (n_full > MAX_CUR) ? MAX_CUR : n_full;

   // width clamp to [2, 4] half-millisecond units
   always_comb begin
      lo   = CB'(cfg.half_ms_ticks) << 1;
      hi   = CB'(cfg.half_ms_ticks) << 2;
      wreq = CB'(item.width);
      if (lo > WMASK_EXT) lo = WMASK_EXT;
      if (hi > WMASK_EXT) hi = WMASK_EXT;
      if (wreq < lo) begin
         clamped = lo;
      end else if (wreq > hi) begin
         clamped = hi;
      end else begin
         clamped = wreq;
      end
   end

   assign wr_data = clamped[WIDTH_BITS-1:0];

   always_comb begin
      logic [ES_BITS-1:0]  esum;
      logic [CUR_BITS-1:0] cur_inc;
      cur_in       = cur_ff;
      elapsed_in   = elapsed_ff;
      countdown_in = countdown_ff;
      done_in      = done_ff;
      rst_line_in  = rst_line_ff;
      pulse        = 1'b0;
      data         = 1'b0;
      wr_en        = 1'b0;
      esum         = ES_BITS'(elapsed_ff) + ES_BITS'(wa);
      cur_inc      = cur_ff + CUR_BITS'(1);
      if (commit) begin
         unique case (item.action)
            ACT_TICK: begin
               if (!done_ff && cur_ff < n_act) begin
                  if (countdown_ff > CD_BITS'(1)) begin
                     countdown_in = countdown_ff - CD_BITS'(1);
                  end else begin
                     pulse        = 1'b1;
                     elapsed_in   = (esum > ES_BITS'(ELAPSED_MAX)) ?
                                    ELAPSED_MAX : esum[ELAPSED_BITS-1:0];
                     countdown_in = CD_BITS'(wa);
                     if (cur_inc == n_act) begin
                        // last channel repeats until the frame time is passed
                        if (elapsed_in > ELAPSED_BITS'(cfg.frame_ticks)) begin
                           done_in = 1'b1;
                           cur_in  = cur_inc;
                        end
                     end else begin
                        cur_in = cur_inc;
                     end
                  end
               end
            end
            ACT_SET: begin
               wr_en = ({1'b0, item.channel} < MAX_CUR);
            end
            ACT_START: begin
               cur_in       = '0;
               done_in      = 1'b0;
               elapsed_in   = '0;
               countdown_in = CD_BITS'(START_DELAY);
               rst_line_in  = cfg.armed;
               pulse        = 1'b1;
               data         = 1'b1;
            end
            ACT_CLEAR: begin
               done_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // running totals per active count, updated by the write delta
   always_comb begin
      for (int k = 0; k < NSUM; k++) begin
         sum_in[k] = sum_ff[k];
         if (wr_en && (k + BASE_CHANNELS) > int'(item.channel)) begin
            sum_in[k] = sum_ff[k] + TOT_BITS'(wr_data) - TOT_BITS'(wb);
         end
      end
      tot_sel = sum_in[0];
      for (int k = 0; k < NSUM; k++) begin
         if (n_act == CUR_BITS'(k + BASE_CHANNELS)) tot_sel = sum_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         elapsed_ff   <= '0;
         countdown_ff <= CD_BITS'(START_DELAY);
         done_ff      <= 1'b0;
         rst_line_ff  <= 1'b0;
         for (int k = 0; k < NSUM; k++) begin
            sum_ff[k] <= TOT_BITS'((k + BASE_CHANNELS) * RESET_WIDTH);
         end
      end else begin
         cur_ff       <= cur_in;
         elapsed_ff   <= elapsed_in;
         countdown_ff <= countdown_in;
         done_ff      <= done_in;
         rst_line_ff  <= rst_line_in;
         for (int k = 0; k < NSUM; k++) begin
            sum_ff[k] <= sum_in[k];
         end
      end
   end

   // reads follow the state left by the request committing this cycle
   assign ra_addr = (cur_in < MAX_CUR) ? cur_in[AW-1:0] : '0;
   assign rb_addr = ({1'b0, req_channel} < MAX_CUR) ? req_channel[AW-1:0] : '0;

   spts_width_mem #(
      .DEPTH       (MAX_CHANNELS),
      .DATA_BITS   (WIDTH_BITS),
      .RESET_VALUE (RESET_WIDTH)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (item.channel[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (load),
      .ra_addr (ra_addr),
      .rb_addr (rb_addr),
      .ra_data (wa),
      .rb_data (wb)
   );

   assign result.clock_pulse = pulse;
   assign result.shift_data  = data;
   assign result.shift_reset = rst_line_in;
   assign result.frame_done  = done_in;
   assign result.channel_now = cur_in;
   assign result.total_width = TOTAL_BITS'(tot_sel);

   `SPTS_CHECK(a_done_at_end, !done_ff || cur_ff >= CUR_BITS'(BASE_CHANNELS), "done before last channel")
   `SPTS_CHECK(a_cur_range, cur_ff <= MAX_CUR, "current channel past table")
   `SPTS_CHECK_NEXT(a_elapsed_grows, commit && item.action != ACT_START, elapsed_ff >= $past(elapsed_ff), "elapsed went down within a frame")

endmodule
